// File: sv/assert_macros.svh
// Assertion macros shared by the list store RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked on every clock edge out of reset.
`define OLS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define OLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ols_pkg.sv
// Shared types and field widths for the ordered list store.
// No dependencies.
package ols_pkg;

    localparam int ACTION_W = 2;
    localparam int ITEM_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_SEARCH = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // write strobes for the slot store
    typedef struct packed {
        logic link_we;
        logic ent_we;
    } mem_ctl_t;

endpackage

// File: sv/ols_if.sv
// Valid/ready channel interfaces for the ordered list store.
// Depends on ols_pkg for field widths.
interface ols_in_if;
    logic                          valid;
    logic                          ready;
    logic [ols_pkg::ACTION_W-1:0]  action;
    logic signed [ols_pkg::ITEM_W-1:0] item_value;
    logic [ols_pkg::POS_W-1:0]     position;

    modport source (output valid, output action, output item_value, output position,
                    input ready);
    modport sink   (input valid, input action, input item_value, input position,
                    output ready);
endinterface

interface ols_out_if;
    logic                          valid;
    logic                          ready;
    logic [ols_pkg::STATUS_W-1:0]  status;
    logic [ols_pkg::POS_W-1:0]     found_position;
    logic [ols_pkg::POS_W-1:0]     entry_count;

    modport source (output valid, output status, output found_position,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_position,
                    input entry_count, output ready);
endinterface

// File: sv/ols_mem.sv
// Slot store: value memory and link memory, one write and one read port each.
// Read data registered. Depends on ols_pkg.
module ols_mem #(
    parameter int DEPTH  = 16,
    parameter int SLOT_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  ols_pkg::mem_ctl_t ctl,
    input  logic [SLOT_W-1:0] link_waddr,
    input  logic [SLOT_W-1:0] link_wdata,
    input  logic [SLOT_W-1:0] link_raddr,
    output logic [SLOT_W-1:0] link_rdata,
    input  logic [SLOT_W-1:0] ent_waddr,
    input  logic [DATA_W-1:0] ent_wdata,
    input  logic [SLOT_W-1:0] ent_raddr,
    output logic [DATA_W-1:0] ent_rdata
);

    logic [SLOT_W-1:0] link_mem [DEPTH];
    logic [DATA_W-1:0] ent_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata <= ent_mem[ent_raddr];
    end

endmodule

// File: sv/ordered_list_store.sv
// Ordered list store: bounded singly linked list of signed values.
// Depends on ols_pkg, ols_if.sv, ols_mem and assert_macros.svh.
//
//  Channel | Dir | Fields                                   | Beat taken when
//  --------+-----+------------------------------------------+-------------------
//  req     | in  | action, item_value, position             | valid && ready
//  rsp     | out | status, found_position, entry_count      | valid && ready
//
//  One beat on req gives exactly one beat on rsp.
//  Append/insert pass through decide and write, with a take step when a
//  recycled slot is popped off the free chain; delete walks to position
//  and then frees the slot; search walks until a match or the tail. The
//  link memory's registered read sets the walk: one list entry per cycle.
//  req.ready is high only while the sequencer is idle; a finished result
//  sits in the rsp register, so a new item can be taken while it waits.
//  A stalled rsp holds the sequencer in its response state.
//  Reset is asynchronous and clears only the control state; memories have
//  no reset and need no clearing pass.
`include "assert_macros.svh"

module ordered_list_store #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ols_in_if.sink    req,
    ols_out_if.source rsp
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > ols_pkg::POS_W) ? CNT_W : ols_pkg::POS_W;
    // values are held as the low bits of the 32-bit input field
    localparam int SW     = (VALUE_WIDTH < ols_pkg::ITEM_W) ? VALUE_WIDTH : ols_pkg::ITEM_W;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DECIDE   = 8'b0000_0010,
        ST_TAKE     = 8'b0000_0100,
        ST_WRITE    = 8'b0000_1000,
        ST_DEL_WALK = 8'b0001_0000,
        ST_DEL_FREE = 8'b0010_0000,
        ST_SRCH     = 8'b0100_0000,
        ST_RESP     = 8'b1000_0000
    } state_t;

    // control state
    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    // high-water mark: slots below it have been used at least once;
    // slots freed since sit on a chain through the link memory
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic              out_valid_reg, out_valid_next;

    // item and walk registers
    ols_pkg::action_t  act_reg, act_next;
    logic [SW-1:0]     val_reg, val_next;
    logic [ols_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] free_head_reg, free_head_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] prev_reg, prev_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    ols_pkg::status_t  status_reg, status_next;
    logic [CNT_W-1:0]  found_reg, found_next;

    // result register
    ols_pkg::status_t          out_status_reg, out_status_next;
    logic [ols_pkg::POS_W-1:0] out_found_reg, out_found_next;
    logic [ols_pkg::POS_W-1:0] out_count_reg, out_count_next;

    // memory ports
    ols_pkg::mem_ctl_t mem_ctl;
    logic [SLOT_W-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
    logic [SLOT_W-1:0] ent_waddr, ent_raddr;
    logic [SW-1:0]     ent_wdata, ent_rdata;

    logic              req_acc;
    logic [CMP_W-1:0]  pos_ext, count_ext, k_ext, found_ext;

    assign req_acc   = req.valid && req.ready;
    assign pos_ext   = CMP_W'(pos_reg);
    assign count_ext = CMP_W'(count_reg);
    assign k_ext     = CMP_W'(k_reg);
    assign found_ext = CMP_W'(found_reg);

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.entry_count    = out_count_reg;

    ols_mem #(
        .DEPTH  (CAPACITY),
        .SLOT_W (SLOT_W),
        .DATA_W (SW)
    ) u_mem (
        .clk        (clk),
        .ctl        (mem_ctl),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata),
        .ent_waddr  (ent_waddr),
        .ent_wdata  (ent_wdata),
        .ent_raddr  (ent_raddr),
        .ent_rdata  (ent_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        hw_next         = hw_reg;
        out_valid_next  = out_valid_reg;
        act_next        = act_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        free_head_next  = free_head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        slot_next       = slot_reg;
        k_next          = k_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;

        mem_ctl    = '0;
        link_waddr = cur_reg;
        link_wdata = free_head_reg;
        link_raddr = cur_reg;
        ent_waddr  = slot_reg;
        ent_wdata  = val_reg;
        ent_raddr  = cur_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    act_next   = ols_pkg::action_t'(req.action);
                    val_next   = req.item_value[SW-1:0];
                    pos_next   = req.position;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                status_next = ols_pkg::STAT_OK;
                found_next  = '0;
                case (act_reg)
                    ols_pkg::ACT_APPEND, ols_pkg::ACT_INSERT:
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ols_pkg::STAT_FULL;
                            state_next  = ST_RESP;
                        end
                        else if (count_reg < hw_reg)
                        begin
                            // pop the free chain; its next link arrives next cycle
                            link_raddr = free_head_reg;
                            slot_next  = free_head_reg;
                            state_next = ST_TAKE;
                        end
                        else
                        begin
                            slot_next  = hw_reg[SLOT_W-1:0];
                            hw_next    = hw_reg + CNT_W'(1);
                            state_next = ST_WRITE;
                        end
                    end
                    ols_pkg::ACT_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ols_pkg::STAT_EMPTY;
                            state_next  = ST_RESP;
                        end
                        else if (pos_ext == '0 || pos_ext > count_ext)
                        begin
                            status_next = ols_pkg::STAT_RANGE;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            link_raddr = head_reg;
                            cur_next   = head_reg;
                            prev_next  = head_reg;
                            k_next     = CNT_W'(1);
                            state_next = ST_DEL_WALK;
                        end
                    end
                    ols_pkg::ACT_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            link_raddr = head_reg;
                            ent_raddr  = head_reg;
                            k_next     = CNT_W'(1);
                            state_next = ST_SRCH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_TAKE:
            begin
                free_head_next = link_rdata;
                state_next     = ST_WRITE;
            end

            ST_WRITE:
            begin
                mem_ctl.ent_we = 1'b1;
                if (act_reg == ols_pkg::ACT_APPEND)
                begin
                    // the tail's link is never followed, so it stays stale
                    if (count_reg != '0)
                    begin
                        mem_ctl.link_we = 1'b1;
                        link_waddr      = tail_reg;
                        link_wdata      = slot_reg;
                    end
                    else
                    begin
                        head_next = slot_reg;
                    end
                    tail_next = slot_reg;
                end
                else
                begin
                    mem_ctl.link_we = 1'b1;
                    link_waddr      = slot_reg;
                    link_wdata      = head_reg;
                    if (count_reg == '0)
                    begin
                        tail_next = slot_reg;
                    end
                    head_next = slot_reg;
                end
                count_next = count_reg + CNT_W'(1);
                state_next = ST_RESP;
            end

            ST_DEL_WALK:
            begin
                // link_rdata holds the link of cur_reg
                if (k_ext < pos_ext)
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    link_raddr = link_rdata;
                    k_next     = k_reg + CNT_W'(1);
                end
                else
                begin
                    if (pos_reg == ols_pkg::POS_W'(1))
                    begin
                        head_next = link_rdata;
                    end
                    else
                    begin
                        mem_ctl.link_we = 1'b1;
                        link_waddr      = prev_reg;
                        link_wdata      = link_rdata;
                    end
                    if (pos_ext == count_ext)
                    begin
                        tail_next = prev_reg;
                    end
                    state_next = ST_DEL_FREE;
                end
            end

            ST_DEL_FREE:
            begin
                // push the unlinked slot onto the free chain
                mem_ctl.link_we = 1'b1;
                link_waddr      = cur_reg;
                link_wdata      = free_head_reg;
                free_head_next  = cur_reg;
                count_next      = count_reg - CNT_W'(1);
                state_next      = ST_RESP;
            end

            ST_SRCH:
            begin
                if (ent_rdata == val_reg)
                begin
                    found_next = k_reg;
                    state_next = ST_RESP;
                end
                else if (k_reg == count_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    link_raddr = link_rdata;
                    ent_raddr  = link_rdata;
                    k_next     = k_reg + CNT_W'(1);
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = found_ext[ols_pkg::POS_W-1:0];
                    out_count_next  = count_ext[ols_pkg::POS_W-1:0];
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            hw_reg        <= hw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        free_head_reg  <= free_head_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        slot_reg       <= slot_next;
        k_reg          <= k_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    // free-chain accounting: recycled slots are hw_reg - count_reg
    `OLS_ASSERT(a_count_cap, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `OLS_ASSERT(a_hw_count, hw_reg >= count_reg, "high-water mark below entry count")
    `OLS_ASSERT(a_srch_bound, state_reg != ST_SRCH || (k_reg != '0 && k_reg <= count_reg), "search walked past the tail")
    `OLS_ASSERT_NEXT(a_rsp_src, state_reg != ST_RESP, !$rose(out_valid_reg), "result raised outside response state")

endmodule
